FILE: hw/rtl/two_wave_gesture_detect_core_assert.svh
// assertion macros shared by the two-wave gesture detector rtl
`ifndef TWO_WAVE_GESTURE_DETECT_CORE_ASSERT_SVH
`define TWO_WAVE_GESTURE_DETECT_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, switched off while reset is low
`define TWGD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("twgd assertion failed");

// clocked check that also holds during reset
`define TWGD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("twgd assertion failed");

`else

`define TWGD_ASSERT(label, clk, rst_n, prop)
`define TWGD_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: hw/rtl/twgd_pkg.sv
// types, codes and reset values of the two-wave gesture detector
package twgd_pkg;

    // field widths
    localparam int DistW   = 11;
    localparam int StampW  = 32;
    localparam int WaveW   = 10;
    localparam int DelayW  = 16;
    localparam int StatusW = 2;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 16;

    typedef logic signed [DistW-1:0] t_dist;
    typedef logic [StampW-1:0]       t_stamp;
    typedef logic [WaveW-1:0]        t_wave;
    typedef logic [DelayW-1:0]       t_delay;
    typedef logic [StatusW-1:0]      t_status;
    typedef logic [CfgIdxW-1:0]      t_cfg_idx;
    typedef logic [CfgW-1:0]         t_cfg_data;

    // result codes
    localparam t_status ST_NOT_READY    = 2'd0;
    localparam t_status ST_NOT_DETECTED = 2'd1;
    localparam t_status ST_DETECTED     = 2'd2;

    // register indexes
    localparam t_cfg_idx REG_WAVE_DISTANCE = 2'd0;
    localparam t_cfg_idx REG_GAP_DELAY     = 2'd1;
    localparam t_cfg_idx REG_WINDOW        = 2'd2;

    // register reset values
    localparam t_wave  WAVE_DISTANCE_RST = 10'd30;
    localparam t_delay GAP_DELAY_RST     = 16'd300;
    localparam t_delay WINDOW_RST        = 16'd500;

    // gesture phases
    typedef enum logic [2:0] {
        PH_IDLE      = 3'b001,
        PH_FIRST     = 3'b010,
        PH_WITHDRAWN = 3'b100
    } t_phase;

    // live configuration seen by the decision logic
    typedef struct packed {
        t_wave  wave_distance;
        t_delay gap_delay_ms;
        t_delay second_wave_window_ms;
    } t_cfg;

endpackage

FILE: hw/rtl/twgd_poll_if.sv
// request channel carrying one distance poll
interface twgd_poll_if;
    import twgd_pkg::*;

    logic   valid;
    logic   ready;
    t_dist  distance_cm;
    t_stamp now_ms;

    modport source (output valid, output distance_cm, output now_ms, input ready);
    modport sink   (input valid, input distance_cm, input now_ms, output ready);
endinterface

FILE: hw/rtl/twgd_result_if.sv
// request channel carrying one poll status
interface twgd_result_if;
    import twgd_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

FILE: hw/rtl/two_wave_gesture_detect_core.sv
// top level of the two-wave gesture detector
//
// Usage: each request on i_poll is one sensor poll (distance_cm, -1 for no
// echo, and a free-running millisecond stamp now_ms). Each poll yields exactly
// one request on o_result whose status is 0 not ready yet, 1 gesture not
// detected or 2 gesture detected, in poll order.
// Pipeline: a poll accepted into the input register goes through the
// combinational decision into the result register, which drives o_result.
// Throughput: one poll per cycle while o_result.ready does not stall the
// result register.
// Configuration: i_cfg_wr_en with i_cfg_index 0 wave_distance, 1 gap_delay_ms,
// 2 second_wave_window_ms writes i_cfg_data at the edge; other indexes are
// ignored. Write only while no poll is in flight.
// Reset (synchronous, i_rst_n low): phase returns to idle, registers take
// 30 cm, 300 ms and 500 ms, both pipeline stages empty.
// Stall: while o_result.ready is low the result holds and one more poll can
// wait in the input register; then i_poll.ready drops.
`include "two_wave_gesture_detect_core_assert.svh"

module two_wave_gesture_detect_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  twgd_pkg::t_cfg_idx  i_cfg_index,
    input  twgd_pkg::t_cfg_data i_cfg_data,
    twgd_poll_if.sink           i_poll,
    twgd_result_if.source       o_result
);
    import twgd_pkg::*;

    t_cfg    cfg;
    logic    r_in_valid;
    t_dist   r_in_distance_cm;
    t_stamp  r_in_now_ms;
    logic    r_out_valid;
    t_status r_out_status;
    t_status step_status;
    logic    advance;
    logic    in_take;

    twgd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // pipeline moves when the result register is free or being drained
    assign advance = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_poll.ready = !r_in_valid || advance;
    assign in_take = i_poll.valid && i_poll.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_poll.ready) begin
            r_in_valid <= i_poll.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_distance_cm <= i_poll.distance_cm;
            r_in_now_ms      <= i_poll.now_ms;
        end
    end

    twgd_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_cfg         (cfg),
        .i_distance_cm (r_in_distance_cm),
        .i_now_ms      (r_in_now_ms),
        .o_status      (step_status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_status <= step_status;
        end
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.status = r_out_status;

    // an empty result stage never blocks new polls
    `TWGD_ASSERT(a_ready_when_empty, i_clk, i_rst_n,
        !r_out_valid |-> i_poll.ready)
    // a waiting poll moves on as soon as the result stage is free
    `TWGD_ASSERT(a_no_bubble, i_clk, i_rst_n,
        (r_in_valid && !r_out_valid) |-> advance)
    // a stalled result is never overwritten
    `TWGD_ASSERT(a_no_overwrite, i_clk, i_rst_n,
        (r_out_valid && !o_result.ready) |=> (r_out_valid && $stable(r_out_status)))
endmodule

FILE: hw/rtl/twgd_cfg_regs.sv
// configuration registers of the gesture detector
module twgd_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  twgd_pkg::t_cfg_idx  i_cfg_index,
    input  twgd_pkg::t_cfg_data i_cfg_data,
    output twgd_pkg::t_cfg      o_cfg
);
    import twgd_pkg::*;

    t_cfg r_cfg;

    // indexed write, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_distance         <= WAVE_DISTANCE_RST;
            r_cfg.gap_delay_ms          <= GAP_DELAY_RST;
            r_cfg.second_wave_window_ms <= WINDOW_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_WAVE_DISTANCE: r_cfg.wave_distance         <= i_cfg_data[WaveW-1:0];
                REG_GAP_DELAY:     r_cfg.gap_delay_ms          <= i_cfg_data[DelayW-1:0];
                REG_WINDOW:        r_cfg.second_wave_window_ms <= i_cfg_data[DelayW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

FILE: hw/rtl/twgd_step.sv
// phase tracking and per-poll decision of the gesture detector
`include "two_wave_gesture_detect_core_assert.svh"

module twgd_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  twgd_pkg::t_cfg    i_cfg,
    input  twgd_pkg::t_dist   i_distance_cm,
    input  twgd_pkg::t_stamp  i_now_ms,
    output twgd_pkg::t_status o_status
);
    import twgd_pkg::*;

    t_phase  r_phase;
    t_phase  n_phase;
    t_stamp  r_start_stamp;
    t_stamp  n_start_stamp;
    t_stamp  elapsed;
    t_status status;
    logic    is_neg;
    logic    is_near;
    logic    is_out;

    // distance classification, negative means no echo
    assign is_neg  = i_distance_cm[DistW-1];
    assign is_near = !is_neg && (i_distance_cm != '0)
                     && (i_distance_cm[WaveW-1:0] < i_cfg.wave_distance);
    assign is_out  = is_neg || (i_distance_cm[WaveW-1:0] > i_cfg.wave_distance);

    // wrapping time since the phase started
    assign elapsed = i_now_ms - r_start_stamp;

    // next phase and status
    always_comb begin
        n_phase       = r_phase;
        n_start_stamp = r_start_stamp;
        status        = ST_NOT_DETECTED;
        unique case (r_phase)
            PH_FIRST: begin
                if (elapsed < {{(StampW-DelayW){1'b0}}, i_cfg.gap_delay_ms}) begin
                    status = ST_NOT_READY;
                end else if (is_out) begin
                    n_phase       = PH_WITHDRAWN;
                    n_start_stamp = i_now_ms;
                    status        = ST_NOT_READY;
                end else begin
                    n_phase = PH_IDLE;
                    status  = ST_NOT_DETECTED;
                end
            end
            PH_WITHDRAWN: begin
                if (elapsed > {{(StampW-DelayW){1'b0}}, i_cfg.second_wave_window_ms}) begin
                    n_phase = PH_IDLE;
                    status  = ST_NOT_DETECTED;
                end else if (is_near) begin
                    n_phase = PH_IDLE;
                    status  = ST_DETECTED;
                end else begin
                    status = ST_NOT_READY;
                end
            end
            default: begin
                if (is_near) begin
                    n_phase       = PH_FIRST;
                    n_start_stamp = i_now_ms;
                    status        = ST_NOT_READY;
                end else begin
                    n_phase = PH_IDLE;
                    status  = ST_NOT_DETECTED;
                end
            end
        endcase
    end

    // phase state, updated once per poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_start_stamp <= '0;
        end else if (i_en) begin
            r_phase       <= n_phase;
            r_start_stamp <= n_start_stamp;
        end
    end

    assign o_status = status;

    // a detection always ends the gesture
    `TWGD_ASSERT(a_detect_to_idle, i_clk, i_rst_n,
        (i_en && status == ST_DETECTED) |=> (r_phase == PH_IDLE))
    // no poll, no state change
    `TWGD_ASSERT(a_hold_when_idle, i_clk, i_rst_n,
        !i_en |=> ($stable(r_phase) && $stable(r_start_stamp)))
    // a first wave stamps the poll time
    `TWGD_ASSERT(a_first_stamp, i_clk, i_rst_n,
        (i_en && r_phase == PH_IDLE && status == ST_NOT_READY)
        |=> (r_phase == PH_FIRST && r_start_stamp == $past(i_now_ms)))
endmodule

FILE: sim/two_wave_gesture_detect_core_tb.sv
// self-checking testbench for the two-wave gesture detector core
module two_wave_gesture_detect_core_tb;
    import twgd_pkg::*;

    // index with no register behind it, writes must be dropped
    localparam t_cfg_idx REG_SPARE    = 2'd3;
    localparam int       PHASE_ITEMS  = 84;
    localparam int       NUM_PHASES   = 7;
    localparam int       STALL_LIMIT  = 2000;
    localparam int       MAX_REPORTS  = 10;
    localparam int       DIR_ROWS     = 24;

    typedef enum logic [1:0] {
        GP_IDLE,
        GP_FIRST,
        GP_WITHDRAWN
    } t_gphase;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PERIODIC
    } t_sink_mode;

    // one directed poll; fixed rows carry their status, the rest follow the predictor
    typedef struct packed {
        t_dist   dist_cm;
        t_stamp  now;
        logic    fixed;
        t_status want;
    } t_poll_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      cfg_wr_en;
    t_cfg_idx  cfg_index;
    t_cfg_data cfg_data;

    twgd_poll_if   poll_ch();
    twgd_result_if status_ch();

    two_wave_gesture_detect_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_poll      (poll_ch),
        .o_result    (status_ch)
    );

    // gesture tracker state and copy of the live registers
    t_gphase gest_phase;
    t_stamp  gest_start;
    t_wave   wave_cm;
    t_delay  gap_ms;
    t_delay  window_ms;

    t_status   status_q[$];
    t_status   predicted_st;
    t_status   want_st;
    logic      row_fixed;
    t_status   row_want;
    t_poll_row dir_rows [DIR_ROWS];
    int        mismatches  = 0;
    int        idle_cycles = 0;
    int        burst_left;
    int        items_sent;
    t_stamp    clock_ms;

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected status of one poll, advances the tracker state
    function automatic t_status predict_status(t_dist d, t_stamp now);
        int      dv;
        int      wv;
        t_stamp  elapsed;
        bit      near_hit;
        bit      hand_out;
        t_status st;
        dv       = int'(d);
        wv       = int'(wave_cm);
        elapsed  = now - gest_start;
        near_hit = dv > 0 && dv < wv;
        hand_out = dv < 0 || dv > wv;
        case (gest_phase)
            GP_FIRST: begin
                if (elapsed < gap_ms) begin
                    st = ST_NOT_READY;
                end else if (hand_out) begin
                    gest_phase = GP_WITHDRAWN;
                    gest_start = now;
                    st         = ST_NOT_READY;
                end else begin
                    gest_phase = GP_IDLE;
                    st         = ST_NOT_DETECTED;
                end
            end
            GP_WITHDRAWN: begin
                if (elapsed > window_ms) begin
                    gest_phase = GP_IDLE;
                    st         = ST_NOT_DETECTED;
                end else if (near_hit) begin
                    gest_phase = GP_IDLE;
                    st         = ST_DETECTED;
                end else begin
                    st = ST_NOT_READY;
                end
            end
            default: begin
                if (near_hit) begin
                    gest_phase = GP_FIRST;
                    gest_start = now;
                    st         = ST_NOT_READY;
                end else begin
                    gest_phase = GP_IDLE;
                    st         = ST_NOT_DETECTED;
                end
            end
        endcase
        return st;
    endfunction

    // distance pickers relative to the current threshold
    function automatic t_dist near_dist();
        return t_dist'($urandom_range(1, int'(wave_cm) - 1));
    endfunction

    function automatic t_dist out_dist();
        case ($urandom_range(0, 2))
            0: return t_dist'(-1);
            1: return t_dist'($urandom_range(1024, 2047));
            default: begin
                if (wave_cm < 10'd1023)
                    return t_dist'($urandom_range(int'(wave_cm) + 1, 1023));
                else
                    return t_dist'(-1);
            end
        endcase
    endfunction

    function automatic t_dist any_dist();
        return t_dist'($urandom_range(0, 2047));
    endfunction

    // never a near hit: hand out, exactly at the threshold, or zero
    function automatic t_dist still_dist();
        case ($urandom_range(0, 3))
            0: return t_dist'({1'b0, wave_cm});
            1: return t_dist'(0);
            default: return out_dist();
        endcase
    endfunction

    function automatic t_dist mixed_dist();
        case ($urandom_range(0, 3))
            0: return any_dist();
            1: return (wave_cm >= 10'd2) ? near_dist() : t_dist'(0);
            2: return t_dist'({1'b0, wave_cm});
            default: return out_dist();
        endcase
    endfunction

    // accepted polls feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && poll_ch.valid && poll_ch.ready) begin
            predicted_st = predict_status(poll_ch.distance_cm, poll_ch.now_ms);
            status_q.push_back(row_fixed ? row_want : predicted_st);
        end
    end

    // accepted statuses checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && status_ch.valid && status_ch.ready) begin
            if (status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("status %0d arrived with nothing expected", status_ch.status);
            end else begin
                want_st = status_q.pop_front();
                if (status_ch.status !== want_st) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("status mismatch: expected %0d, got %0d",
                                 want_st, status_ch.status);
                end
            end
        end
    end

    // watchdog on cycles with no accepted request on either channel
    always @(posedge i_clk) begin
        if ((poll_ch.valid && poll_ch.ready) || (status_ch.valid && status_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("two_wave_gesture_detect_core_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side stalls in stretches of its own
    initial begin
        t_sink_mode mode;
        int         mode_left;
        status_ch.ready = 1'b0;
        mode            = SINK_OPEN;
        mode_left       = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                SINK_OPEN:   status_ch.ready <= 1'b1;
                SINK_RANDOM: status_ch.ready <= 1'($urandom_range(0, 1));
                default:     status_ch.ready <= (mode_left % 5) < 2;
            endcase
        end
    end

    // one poll request, sent in bursts with random gaps
    task automatic send_poll(t_dist d, t_stamp now, logic fixed = 1'b0,
                             t_status want = ST_NOT_READY);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                poll_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        poll_ch.valid       <= 1'b1;
        poll_ch.distance_cm <= d;
        poll_ch.now_ms      <= now;
        row_fixed           <= fixed;
        row_want            <= want;
        @(posedge i_clk);
        while (!poll_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // stop sending and let every pending status come back
    task automatic drain();
        @(negedge i_clk);
        poll_ch.valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, t_cfg_data data);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WAVE_DISTANCE: wave_cm   = data[WaveW-1:0];
            REG_GAP_DELAY:     gap_ms    = data;
            REG_WINDOW:        window_ms = data;
            default: ;
        endcase
    endtask

    // near, withdraw after the gap, near again; some steps broken or off the edges
    task automatic run_gesture();
        t_stamp      t0;
        t_stamp      t1;
        t_stamp      t2;
        int          n;
        int unsigned slack;
        t0 = clock_ms;
        send_poll(near_dist(), t0);
        n = (gap_ms == 16'd0) ? 0 : $urandom_range(0, 2);
        repeat (n) send_poll(any_dist(), t0 + $urandom_range(0, int'(gap_ms) - 1));
        case ($urandom_range(0, 2))
            0: slack = 0;
            1: slack = $urandom_range(1, 3);
            default: slack = $urandom_range(0, int'(gap_ms) / 4 + 1);
        endcase
        t1 = t0 + gap_ms + slack;
        send_poll(($urandom_range(0, 6) == 0) ? any_dist() : out_dist(), t1);
        n = $urandom_range(0, 2);
        repeat (n) send_poll(still_dist(), t1 + $urandom_range(0, int'(window_ms)));
        case ($urandom_range(0, 3))
            0: t2 = t1 + window_ms;
            1: t2 = t1 + window_ms + 1 + $urandom_range(0, 20);
            default: t2 = t1 + $urandom_range(0, int'(window_ms));
        endcase
        send_poll(($urandom_range(0, 6) == 0) ? any_dist() : near_dist(), t2);
        clock_ms = t2 + $urandom_range(1, 50);
    endtask

    task automatic run_noise();
        if ($urandom_range(0, 9) == 0)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + $urandom_range(0, int'(gap_ms) + int'(window_ms) + 2);
        send_poll(mixed_dist(), clock_ms);
    endtask

    // register settings per phase, extremes first
    task automatic set_registers(int p);
        case (p)
            0: begin
                cfg_write(REG_WAVE_DISTANCE, t_cfg_data'(($urandom_range(0, 63) << 10) | 1023));
                cfg_write(REG_GAP_DELAY, 16'd0);
                cfg_write(REG_WINDOW, 16'd0);
            end
            1: begin
                cfg_write(REG_WAVE_DISTANCE, 16'd0);
                cfg_write(REG_GAP_DELAY, 16'hFFFF);
                cfg_write(REG_WINDOW, 16'hFFFF);
            end
            2: begin
                cfg_write(REG_WAVE_DISTANCE, 16'd1);
                cfg_write(REG_GAP_DELAY, 16'd1);
                cfg_write(REG_WINDOW, 16'd1);
                cfg_write(REG_SPARE, t_cfg_data'($urandom()));
            end
            3: begin
                cfg_write(REG_WAVE_DISTANCE, 16'd2);
                cfg_write(REG_GAP_DELAY, t_cfg_data'($urandom_range(0, 50)));
                cfg_write(REG_WINDOW, t_cfg_data'($urandom_range(0, 50)));
            end
            5: begin
                cfg_write(REG_WAVE_DISTANCE, t_cfg_data'($urandom_range(3, 100)));
                cfg_write(REG_GAP_DELAY, GAP_DELAY_RST);
                cfg_write(REG_WINDOW, WINDOW_RST);
            end
            default: begin
                cfg_write(REG_SPARE, t_cfg_data'($urandom()));
                cfg_write(REG_WAVE_DISTANCE, t_cfg_data'($urandom()));
                cfg_write(REG_GAP_DELAY, t_cfg_data'($urandom()));
                cfg_write(REG_WINDOW, t_cfg_data'($urandom()));
            end
        endcase
    endtask

    initial begin
        int start;
        i_rst_n             = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = REG_WAVE_DISTANCE;
        cfg_data            = '0;
        poll_ch.valid       = 1'b0;
        poll_ch.distance_cm = '0;
        poll_ch.now_ms      = '0;
        row_fixed           = 1'b0;
        row_want            = ST_NOT_READY;
        burst_left          = 0;
        items_sent          = 0;
        clock_ms            = $urandom();
        gest_phase          = GP_IDLE;
        gest_start          = '0;
        wave_cm             = WAVE_DISTANCE_RST;
        gap_ms              = GAP_DELAY_RST;
        window_ms           = WINDOW_RST;

        // directed polls at reset settings: 30 cm, 300 ms, 500 ms
        dir_rows = '{
            // idle: no echo, zero, at threshold, distance extremes
            '{t_dist'(-1),    32'd0,          1'b1, ST_NOT_DETECTED},
            '{t_dist'(0),     32'd5,          1'b1, ST_NOT_DETECTED},
            '{t_dist'(30),    32'd6,          1'b1, ST_NOT_DETECTED},
            '{t_dist'(1023),  32'd7,          1'b1, ST_NOT_DETECTED},
            '{t_dist'(-1024), 32'd8,          1'b1, ST_NOT_DETECTED},
            // first wave, poll inside the gap, then hand at threshold fails
            '{t_dist'(29),    32'd1000,       1'b0, ST_NOT_READY},
            '{t_dist'(10),    32'd1299,       1'b0, ST_NOT_READY},
            '{t_dist'(30),    32'd1300,       1'b0, ST_NOT_READY},
            // gesture across the time stamp wrap, second wave at window edge
            '{t_dist'(1),     32'hFFFF_FF00,  1'b0, ST_NOT_READY},
            '{t_dist'(-1),    32'h0000_002C,  1'b0, ST_NOT_READY},
            '{t_dist'(500),   32'h0000_0220,  1'b0, ST_NOT_READY},
            '{t_dist'(29),    32'h0000_0220,  1'b0, ST_NOT_READY},
            // second wave too late
            '{t_dist'(5),     32'd2000,       1'b0, ST_NOT_READY},
            '{t_dist'(40),    32'd2300,       1'b0, ST_NOT_READY},
            '{t_dist'(5),     32'd2801,       1'b0, ST_NOT_READY},
            // withdrawn by a negative distance, non-near polls wait
            '{t_dist'(5),     32'd3000,       1'b0, ST_NOT_READY},
            '{t_dist'(-1024), 32'd3400,       1'b0, ST_NOT_READY},
            '{t_dist'(1023),  32'd3500,       1'b0, ST_NOT_READY},
            '{t_dist'(0),     32'd3600,       1'b0, ST_NOT_READY},
            '{t_dist'(30),    32'd3700,       1'b0, ST_NOT_READY},
            '{t_dist'(15),    32'd3900,       1'b0, ST_NOT_READY},
            // hand still near at the withdrawal check
            '{t_dist'(1),     32'd4000,       1'b0, ST_NOT_READY},
            '{t_dist'(1),     32'd4100,       1'b0, ST_NOT_READY},
            '{t_dist'(29),    32'd4300,       1'b0, ST_NOT_READY}
        };

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_poll(dir_rows[i].dist_cm, dir_rows[i].now, dir_rows[i].fixed,
                      dir_rows[i].want);

        // random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            set_registers(p);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if (wave_cm >= 10'd2 && $urandom_range(0, 9) < 7)
                    run_gesture();
                else
                    run_noise();
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && status_q.size() == 0)
            $display("two_wave_gesture_detect_core_tb: PASS");
        else
            $display("two_wave_gesture_detect_core_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/twgd_pkg.sv
hw/rtl/twgd_poll_if.sv
hw/rtl/twgd_result_if.sv
hw/rtl/twgd_cfg_regs.sv
hw/rtl/twgd_step.sv
hw/rtl/two_wave_gesture_detect_core.sv
sim/two_wave_gesture_detect_core_tb.sv
